FILE: hdl/fqc_pkg.sv
// Shared types and constants for the identifier queue with cancel.
// Used by fqc_ctrl, fqc_dpath and fifo_queue_with_cancel_by_id_top.
package fqc_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned ID_BITS_DEF  = 16;
  localparam int unsigned ID_MAX_BITS  = 32;
  localparam int unsigned ID_FIELD_W   = 16;
  localparam int unsigned COUNT_FIELD_W = 5;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_EXEC = 2'd1,
    CS_RESP = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [ID_FIELD_W-1:0] entry_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [ID_FIELD_W-1:0]    removed_id;
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic [ID_FIELD_W-1:0]    front_id;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

FILE: hdl/fqc_ctrl.sv
// Controller state machine for the identifier queue: sequences capture,
// execution and result hand-over. Depends on fqc_pkg.
module fqc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fqc_pkg::dp_cmd_t cmd_o
);
  import fqc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = CS_EXEC;
        end
      end
      CS_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = CS_RESP;
      end
      CS_RESP: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/fqc_dpath.sv
// Datapath of the identifier queue: request register, row of slot cells
// with per-slot compare and compacting shift, count and result register.
// Depends on fqc_pkg.
module fqc_dpath #(
  parameter int unsigned CAPACITY = fqc_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = fqc_pkg::ID_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fqc_pkg::dp_cmd_t  cmd_i,
  input  fqc_pkg::in_word_t in_word_i,
  output fqc_pkg::out_word_t out_word_o
);
  import fqc_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  in_word_t             req_q;
  out_word_t            res_q, res_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [ID_BITS-1:0]   slot_q [CAPACITY];
  logic [ID_BITS-1:0]   slot_d [CAPACITY];
  logic [ID_BITS-1:0]   slot_nxt [CAPACITY];
  logic [CAPACITY-1:0]  hit, seen, is_tail;
  logic [ID_MAX_BITS-1:0] id_ext;
  logic [ID_BITS-1:0]   id;
  logic                 full, empty, found;

  assign id_ext = ID_MAX_BITS'(req_q.entry_id);
  assign id     = id_ext[ID_BITS-1:0];
  assign full   = (count_q == CntW'(CAPACITY));
  assign empty  = (count_q == '0);

  // Per-slot compare against the request, and the value each cell would
  // take when the entries behind it move forward.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign hit[g]     = (CntW'(g) < count_q) && (slot_q[g] == id);
    assign is_tail[g] = (CntW'(g) == count_q);
    if (g < CAPACITY - 1) begin : g_shift
      assign slot_nxt[g] = slot_q[g+1];
    end else begin : g_last
      assign slot_nxt[g] = slot_q[g];
    end
  end

  // Slots from the first match onwards close up the gap.
  always_comb begin
    seen[0] = hit[0];
    for (int i = 1; i < CAPACITY; i++) begin
      seen[i] = seen[i-1] | hit[i];
    end
  end
  assign found = seen[CAPACITY-1];

  always_comb begin
    count_d = count_q;
    res_d   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_d[i] = slot_q[i];
    end
    case (mode_e'(req_q.mode))
      MODE_ENQ: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (is_tail[i]) slot_d[i] = id;
          end
          count_d = count_q + CntW'(1);
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          res_d.removed_id = ID_FIELD_W'(slot_q[0]);
          for (int i = 0; i < CAPACITY; i++) begin
            slot_d[i] = slot_nxt[i];
          end
          count_d = count_q - CntW'(1);
        end
      end
      MODE_CANCEL: begin
        if (found) begin
          res_d.removed_id = ID_FIELD_W'(id);
          for (int i = 0; i < CAPACITY; i++) begin
            if (seen[i]) slot_d[i] = slot_nxt[i];
          end
          count_d = count_q - CntW'(1);
        end else begin
          res_d.status = ST_NOTFOUND;
        end
      end
      default: begin
        res_d.status = ST_OK;
      end
    endcase
    res_d.entry_count = COUNT_FIELD_W'(count_d);
    res_d.front_id    = (count_d != '0) ? ID_FIELD_W'(slot_d[0]) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_word_i;
    end
    if (cmd_i.execute) begin
      res_q <= res_d;
      for (int i = 0; i < CAPACITY; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  assign out_word_o = res_q;

endmodule

FILE: hdl/fifo_queue_with_cancel_by_id_top.sv
// Top level of the ordered identifier queue with cancel by identifier.
// Instantiates fqc_ctrl and fqc_dpath; depends on fqc_pkg.
//
//   Channel   Direction   Handshake               Word
//   --------  ----------  ----------------------  -------------------------
//   request   in          in_valid_i/in_stall_o   in_word_i  (mode, entry_id)
//   result    out         out_valid_o/out_stall_i out_word_o (status,
//                                                  removed_id, entry_count,
//                                                  front_id)
//
// Each request is captured into the request register, then the whole row of slot
// cells compares, shifts and writes in parallel, then the result word is presented
// for as long as out_stall_i holds it. The next request is taken the cycle after the
// result word leaves.
// Reset clears the controller and the entry count; slot contents are not
// reset and are only ever read below the count.
// While out_stall_i holds the result, in_stall_o stays high.
module fifo_queue_with_cancel_by_id_top #(
  parameter int unsigned CAPACITY = fqc_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = fqc_pkg::ID_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fqc_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fqc_pkg::out_word_t out_word_o
);
  import fqc_pkg::*;

  // Command bundle: capture latches the request, execute applies it.
  dp_cmd_t cmd;

  fqc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the slots with the front in slot zero, so the front
  // identifier and the dequeued identifier need no read multiplexer.
  fqc_dpath #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

FILE: verif/fifo_queue_with_cancel_by_id_tb.sv
// Self-checking testbench for fifo_queue_with_cancel_by_id_top: predicts every result
// word from a queue mirror and checks it against the block's output, mostly under random
// idling on both sides. Depends on fqc_pkg and the RTL of the identifier queue; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fqc_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = CAPACITY_DEF;
  localparam int unsigned IDLE_PERCENT = 17;
  localparam int unsigned REPORT_LIMIT = 10;
  // Identifiers are kept to their low ID_BITS bits inside the block.
  localparam logic [ID_FIELD_W-1:0] ID_KEEP = ID_FIELD_W'((64'd1 << ID_BITS_DEF) - 64'd1);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_word_t  req_word  = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_word_t res_word;

  fifo_queue_with_cancel_by_id_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_stall_o  (req_stall),
    .in_word_i   (req_word),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_word_o  (res_word)
  );

  always #5 clk = ~clk;

  // Mirror of the queue contents, front first, and the result words still owed by the block.
  logic [ID_FIELD_W-1:0] held_ids[$];
  out_word_t             awaited_results[$];
  int unsigned           fault_count     = 0;
  bit                    sender_idles    = 1'b1;
  bit                    receiver_stalls = 1'b1;

  // Applies one request word to the mirror and returns the result word it should produce.
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t             r;
    logic [ID_FIELD_W-1:0] id;
    int                    hit;
    r      = '0;
    r.status = ST_OK;
    id     = w.entry_id & ID_KEEP;
    hit    = -1;
    case (mode_e'(w.mode))
      MODE_ENQ: begin
        if (held_ids.size() >= QUEUE_DEPTH) r.status = ST_FULL;
        else held_ids.push_back(id);
      end
      MODE_DEQ: begin
        if (held_ids.size() == 0) r.status = ST_EMPTY;
        else r.removed_id = held_ids.pop_front();
      end
      MODE_CANCEL: begin
        // Only the first match counted from the front goes; the rest close up behind it.
        foreach (held_ids[i]) if (hit < 0 && held_ids[i] == id) hit = i;
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.removed_id = held_ids[hit];
          held_ids.delete(hit);
        end
      end
      default: ;
    endcase
    r.entry_count = COUNT_FIELD_W'(held_ids.size());
    r.front_id    = (held_ids.size() != 0) ? held_ids[0] : '0;
    return r;
  endfunction

  function automatic void note_fault(string what, out_word_t wanted, out_word_t got);
    fault_count++;
    if (fault_count <= REPORT_LIMIT)
      $display({"%0t: %s: expected status=%0d removed=%h count=%0d front=%h, ",
                "got status=%0d removed=%h count=%0d front=%h"},
               $time, what, wanted.status, wanted.removed_id, wanted.entry_count,
               wanted.front_id, got.status, got.removed_id, got.entry_count, got.front_id);
  endfunction

  // Every result word taken at an edge is compared with the oldest outstanding prediction.
  always @(posedge clk) begin : check_result
    out_word_t wanted;
    if (rst_n && res_valid && !res_stall) begin
      if (awaited_results.size() == 0) begin
        note_fault("result word with none awaited", out_word_t'('0), res_word);
      end else begin
        wanted = awaited_results.pop_front();
        if (res_word.status !== wanted.status || res_word.removed_id !== wanted.removed_id ||
            res_word.entry_count !== wanted.entry_count || res_word.front_id !== wanted.front_id)
          note_fault("result word differs", wanted, res_word);
      end
    end
  end

  always @(posedge clk) res_stall <= receiver_stalls && ($urandom_range(99) < IDLE_PERCENT);

  // Offers one request word and returns at the edge that takes it. Valid is left high so that a
  // following word can go out back to back; callers that wait lower it first.
  task automatic send_request(input mode_e mode, input logic [ID_FIELD_W-1:0] id);
    in_word_t w;
    w.mode     = mode;
    w.entry_id = id;
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (req_stall);
    awaited_results.push_back(apply_request(w));
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // One random request, at times after a no-op one. Enqueues often draw from small pools at
  // both ends of the range so that duplicates occur; most cancels name a held identifier, so they hit.
  task automatic send_random_request(input int unsigned enq_pct, input int unsigned deq_pct);
    int unsigned           roll;
    logic [ID_FIELD_W-1:0] id;
    if ($urandom_range(24) == 0) send_request(MODE_NOP, ID_FIELD_W'($urandom_range(16'hFFFF)));
    roll = $urandom_range(99);
    id   = ID_FIELD_W'($urandom_range(16'hFFFF));
    if (roll < enq_pct) begin
      case ($urandom_range(3))
        0: id = ID_FIELD_W'($urandom_range(7));
        1: id = 16'hFFF8 | ID_FIELD_W'($urandom_range(7));
        default: ;
      endcase
      send_request(MODE_ENQ, id);
    end else if (roll < enq_pct + deq_pct) begin
      send_request(MODE_DEQ, id);
    end else begin
      if (held_ids.size() != 0 && $urandom_range(3) != 0)
        id = held_ids[$urandom_range(held_ids.size() - 1)];
      send_request(MODE_CANCEL, id);
    end
  endtask

  // Alternates blocks that tend to fill the queue with blocks that tend to empty it.
  task automatic send_mixed_traffic(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ((n / 100) % 2 == 0) send_random_request(60, 15);
      else send_random_request(20, 45);
    end
  endtask

  // Dequeue and cancel on an empty queue, and the unused mode with nothing held.
  task automatic test_empty_queue();
    send_request(MODE_DEQ, 16'hFFFF);
    send_request(MODE_CANCEL, 16'h0000);
    send_request(MODE_NOP, 16'hFFFF);
  endtask

  // Fills every slot, with identifiers at both extremes and a duplicate, then tries one more.
  task automatic test_fill_to_full();
    send_request(MODE_ENQ, 16'h0000);
    send_request(MODE_ENQ, 16'hFFFF);
    send_request(MODE_ENQ, 16'h00AA);
    send_request(MODE_ENQ, 16'h5555);
    send_request(MODE_ENQ, 16'hAAAA);
    send_request(MODE_ENQ, 16'h00AA);
    for (int unsigned i = 0; i < QUEUE_DEPTH - 6; i++)
      send_request(MODE_ENQ, 16'h1000 + ID_FIELD_W'(i));
    send_request(MODE_ENQ, 16'h1234);
  endtask

  // Cancel of a duplicated identifier, of the back entry and of the front entry, a cancel
  // that misses, and a dequeue behind them.
  task automatic test_cancel_rules();
    send_request(MODE_CANCEL, 16'h00AA);
    send_request(MODE_CANCEL, 16'h1009);
    send_request(MODE_CANCEL, 16'h0000);
    send_request(MODE_CANCEL, 16'hBEEF);
    send_request(MODE_DEQ, 16'h0000);
  endtask

  // The sender stops until every result word is back, then carries on from a quiet block.
  task automatic test_drain_pause();
    send_mixed_traffic(60);
    hold_until_drained();
    send_mixed_traffic(40);
  endtask

  task automatic test_random_traffic();
    send_mixed_traffic(800);
  endtask

  // A long stretch with neither side idling, so words go through at the block's full rate.
  task automatic test_calm_stretch();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    send_mixed_traffic(150);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_fill_to_full();
    test_cancel_rules();
    test_drain_pause();
    test_random_traffic();
    test_calm_stretch();
    hold_until_drained();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: fifo_queue_with_cancel_by_id_top.f
hdl/fqc_pkg.sv
hdl/fqc_ctrl.sv
hdl/fqc_dpath.sv
hdl/fifo_queue_with_cancel_by_id_top.sv
verif/fifo_queue_with_cancel_by_id_tb.sv
